FILE: hdl/msic_pkg.sv
package msic_pkg;

  // Field widths.
  localparam int VEL_W   = 16;
  localparam int COORD_W = 16;
  localparam int ANGLE_W = 16;
  localparam int RAD_W   = 15;
  localparam int THR_W   = 15;
  localparam int SW_W    = 16;

  // Serial squarers and CORDIC sizing.
  localparam int MAG_W      = (COORD_W > VEL_W) ? COORD_W : VEL_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int SQ_W       = PROD_W + 1;
  localparam int CORDIC_PRE = 24;
  localparam int CX_W       = MAG_W + CORDIC_PRE + 3;
  localparam int STEP_N     = (ANGLE_W > MAG_W) ? ANGLE_W : MAG_W;
  localparam int STEP_W     = $clog2(STEP_N);
  localparam int ATAN_IDX_W = 5;

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [RAD_W-1:0] SECTOR_RADIUS_RST = RAD_W'(1024);
  localparam logic [RAD_W-1:0] CIRCLE_RADIUS_RST = RAD_W'(614);
  localparam logic [SW_W-1:0]  SECTOR_WIDTH_RST  = SW_W'(16384);
  localparam logic [THR_W-1:0] LIN_THR_RST       = THR_W'(51);
  localparam logic [THR_W-1:0] YAW_THR_RST       = THR_W'(51);

  typedef enum logic [2:0] {
    REG_SECTOR_RADIUS = 3'd0,
    REG_CIRCLE_RADIUS = 3'd1,
    REG_SECTOR_WIDTH  = 3'd2,
    REG_LIN_THR       = 3'd3,
    REG_YAW_THR       = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MC_STOPPED     = 2'd0,
    MC_TRANSLATING = 2'd1,
    MC_TURNING     = 2'd2
  } motion_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]   vel_x;
    logic signed [VEL_W-1:0]   vel_y;
    logic signed [VEL_W-1:0]   yaw_rate;
    logic signed [COORD_W-1:0] person_x;
    logic signed [COORD_W-1:0] person_y;
    logic                      person_present;
    logic                      last_in_frame;
  } sample_t;

  typedef struct packed {
    motion_t motion_class;
    logic    person_inside;
    logic    intrusion_so_far;
    logic    frame_done;
  } verdict_t;

  // Arctangent of 2^-i, 2^32 per turn; entries past the table are zero.
  localparam logic [31:0] ATAN_TAB [2**ATAN_IDX_W] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0
  };

endpackage

FILE: hdl/msic_chan_if.sv
interface msic_sample_if import msic_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msic_verdict_if import msic_pkg::*; ();
  logic     valid;
  logic     ready;
  verdict_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/motion_sector_intrusion_check_top.sv
// Channel  | Direction | Payload                                        | Handshake
// sample   | in        | vel_x, vel_y, yaw_rate, person_x, person_y,    | valid/ready
//          |           | person_present, last_in_frame                  |
// verdict  | out       | motion_class, person_inside, intrusion_so_far, | valid/ready
//          |           | frame_done                                     |
// APB      | in/out    | five registers at byte addresses 0, 4, .. 16   | psel/penable
//
// Each item is loaded, then runs 16 steps of the two CORDIC units and the bit-serial
// squarers (one rotation and one multiplier bit per cycle); ST_SUM then sums the
// squares and takes the bearing difference, and ST_DONE compares and loads the result.
// Reset is synchronous; it restores the register defaults and clears the frame flag.
// The finished result waits in the output register; the next item is taken meanwhile
// and only its final cycle holds until that register has been emptied.
module motion_sector_intrusion_check_top import msic_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  msic_sample_if.sink         sample,
  msic_verdict_if.source      verdict,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int OPS    = 7;
  localparam int OP_VX  = 0;
  localparam int OP_VY  = 1;
  localparam int OP_PX  = 2;
  localparam int OP_PY  = 3;
  localparam int OP_LTH = 4;
  localparam int OP_SR  = 5;
  localparam int OP_CR  = 6;
  localparam int DM_W   = ANGLE_W + 1;
  localparam int CMP_W  = ANGLE_W + 18;
  localparam int ANG_CMP_SHIFT = 17;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic [31:0]            z;
  } cordic_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
    return v[MAG_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Scale by 2^CORDIC_PRE and pre-rotate the left half plane by a quarter turn.
  function automatic cordic_t cordic_init(input logic signed [MAG_W-1:0] x0,
                                          input logic signed [MAG_W-1:0] y0);
    cordic_t c;
    logic signed [CX_W-1:0] xs;
    logic signed [CX_W-1:0] ys;
    xs = CX_W'(x0) <<< CORDIC_PRE;
    ys = CX_W'(y0) <<< CORDIC_PRE;
    if (xs < 0) begin
      if (ys >= 0) begin
        c.x = ys;
        c.y = -xs;
        c.z = 32'h40000000;
      end else begin
        c.x = -ys;
        c.y = xs;
        c.z = 32'hC0000000;
      end
    end else begin
      c.x = xs;
      c.y = ys;
      c.z = 32'h0;
    end
    return c;
  endfunction

  function automatic cordic_t cordic_iter(input cordic_t c, input logic [STEP_W-1:0] i);
    cordic_t n;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic [31:0]            a;
    dx = c.y >>> i;
    dy = c.x >>> i;
    a  = ATAN_TAB[ATAN_IDX_W'(i)];
    if (c.y > 0) begin
      n.x = c.x + dx;
      n.y = c.y - dy;
      n.z = c.z + a;
    end else begin
      n.x = c.x - dx;
      n.y = c.y + dy;
      n.z = c.z - a;
    end
    return n;
  endfunction

  function automatic logic [ANGLE_W-1:0] bearing_round(input logic [31:0] z);
    logic [31:0] t;
    t = z + (32'd1 << (31 - ANGLE_W));
    return t[31 -: ANGLE_W];
  endfunction

  // Configuration registers.
  logic [RAD_W-1:0] sector_radius;
  logic [RAD_W-1:0] circle_radius;
  logic [SW_W-1:0]  sector_width;
  logic [THR_W-1:0] lin_thr;
  logic [THR_W-1:0] yaw_thr;
  logic [2:0]       reg_idx;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_radius <= SECTOR_RADIUS_RST;
      circle_radius <= CIRCLE_RADIUS_RST;
      sector_width  <= SECTOR_WIDTH_RST;
      lin_thr       <= LIN_THR_RST;
      yaw_thr       <= YAW_THR_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_SECTOR_RADIUS: sector_radius <= pwdata[RAD_W-1:0];
        REG_CIRCLE_RADIUS: circle_radius <= pwdata[RAD_W-1:0];
        REG_SECTOR_WIDTH:  sector_width  <= pwdata[SW_W-1:0];
        REG_LIN_THR:       lin_thr       <= pwdata[THR_W-1:0];
        REG_YAW_THR:       yaw_thr       <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SECTOR_RADIUS: prdata = DATA_W'(sector_radius);
      REG_CIRCLE_RADIUS: prdata = DATA_W'(circle_radius);
      REG_SECTOR_WIDTH:  prdata = DATA_W'(sector_width);
      REG_LIN_THR:       prdata = DATA_W'(lin_thr);
      REG_YAW_THR:       prdata = DATA_W'(yaw_thr);
      default:           prdata = '0;
    endcase
  end

  // Control.
  state_t            state;
  logic [STEP_W-1:0] step;
  logic              out_valid;
  verdict_t          out_data;
  logic              accum;
  logic              out_free;

  // Datapath.
  logic [PROD_W-1:0] mc [OPS];
  logic [MAG_W-1:0]  ml [OPS];
  logic [PROD_W-1:0] sq [OPS];
  cordic_t           vel_c;
  cordic_t           per_c;
  logic              vel_zero;
  logic              per_zero;
  logic              present;
  logic              last;
  logic              yaw_fast;
  logic [SQ_W-1:0]   speed_sum;
  logic [SQ_W-1:0]   dist_sum;
  logic [DM_W-1:0]   dmag;

  logic [MAG_W-1:0]   op_in [OPS];
  logic [ANGLE_W-1:0] b_per;
  logic [ANGLE_W-1:0] b_vel;
  logic [ANGLE_W-1:0] b_diff;
  logic               is_translating;
  logic               is_turning;
  logic               sector_hit;
  logic               circle_hit;
  logic               zone_hit;
  logic               so_far;
  motion_t            mclass;

  assign sample.ready  = (state == ST_IDLE);
  assign verdict.valid = out_valid;
  assign verdict.data  = out_data;
  assign out_free      = !out_valid || verdict.ready;

  always_comb begin
    op_in[OP_VX]  = mag(MAG_W'(sample.data.vel_x));
    op_in[OP_VY]  = mag(MAG_W'(sample.data.vel_y));
    op_in[OP_PX]  = mag(MAG_W'(sample.data.person_x));
    op_in[OP_PY]  = mag(MAG_W'(sample.data.person_y));
    op_in[OP_LTH] = MAG_W'(lin_thr);
    op_in[OP_SR]  = MAG_W'(sector_radius);
    op_in[OP_CR]  = MAG_W'(circle_radius);
  end

  always_comb begin
    b_per  = per_zero ? '0 : bearing_round(per_c.z);
    b_vel  = vel_zero ? '0 : bearing_round(vel_c.z);
    b_diff = b_per - b_vel;
  end

  always_comb begin
    is_translating = speed_sum > SQ_W'(sq[OP_LTH]);
    is_turning     = !is_translating && yaw_fast;
    sector_hit     = (dist_sum < SQ_W'(sq[OP_SR])) &&
                     ((CMP_W'(dmag) << ANG_CMP_SHIFT) < (CMP_W'(sector_width) << ANGLE_W));
    circle_hit     = dist_sum < SQ_W'(sq[OP_CR]);
    if (is_translating) begin
      mclass = MC_TRANSLATING;
    end else if (is_turning) begin
      mclass = MC_TURNING;
    end else begin
      mclass = MC_STOPPED;
    end
    zone_hit = present && (is_translating ? sector_hit : (is_turning && circle_hit));
    so_far   = accum || zone_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
      accum     <= 1'b0;
    end else begin
      // A new result may replace the one taken at this very edge.
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (verdict.valid && verdict.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          step <= '0;
          if (sample.valid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == STEP_W'(STEP_N - 1)) begin
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            accum <= last ? 1'b0 : so_far;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample.valid) begin
      for (int k = 0; k < OPS; k++) begin
        mc[k] <= PROD_W'(op_in[k]);
        ml[k] <= op_in[k];
        sq[k] <= '0;
      end
      vel_c    <= cordic_init(MAG_W'(sample.data.vel_x), MAG_W'(sample.data.vel_y));
      per_c    <= cordic_init(MAG_W'(sample.data.person_x), MAG_W'(sample.data.person_y));
      vel_zero <= (sample.data.vel_x == '0) && (sample.data.vel_y == '0);
      per_zero <= (sample.data.person_x == '0) && (sample.data.person_y == '0);
      present  <= sample.data.person_present;
      last     <= sample.data.last_in_frame;
      yaw_fast <= mag(MAG_W'(sample.data.yaw_rate)) > MAG_W'(yaw_thr);
    end
    if (state == ST_RUN) begin
      // One multiplier bit per cycle for every square.
      for (int k = 0; k < OPS; k++) begin
        if (ml[k][0]) begin
          sq[k] <= sq[k] + mc[k];
        end
        mc[k] <= mc[k] << 1;
        ml[k] <= ml[k] >> 1;
      end
      if ({1'b0, step} < (STEP_W + 1)'(ANGLE_W)) begin
        vel_c <= cordic_iter(vel_c, step);
        per_c <= cordic_iter(per_c, step);
      end
    end
    if (state == ST_SUM) begin
      speed_sum <= SQ_W'(sq[OP_VX]) + SQ_W'(sq[OP_VY]);
      dist_sum  <= SQ_W'(sq[OP_PX]) + SQ_W'(sq[OP_PY]);
      // Magnitude of the wrapped bearing difference; a half turn stays positive.
      dmag      <= b_diff[ANGLE_W-1] ? ((DM_W'(1) << ANGLE_W) - {1'b0, b_diff})
                                     : {1'b0, b_diff};
    end
    if (state == ST_DONE && out_free) begin
      out_data.motion_class     <= mclass;
      out_data.person_inside    <= zone_hit;
      out_data.intrusion_so_far <= so_far;
      out_data.frame_done       <= last;
    end
  end

endmodule
